>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// widths and shared types for the extended gcd unit
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/egcd_divider.sv
// ----------------------------------------------------------------------------
// egcd_divider
// iterative signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module egcd_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [egcd_pkg::WIDTH-1:0] dividend,
  input  logic signed [egcd_pkg::WIDTH-1:0] divisor,
  output egcd_pkg::div_stat_t              stat,
  output logic        [egcd_pkg::WIDTH-1:0] quotient,
  output logic signed [egcd_pkg::WIDTH-1:0] remainder
);
  import egcd_pkg::*;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            quo_r, quo_nxt;
  word_t            rem_r, rem_nxt;
  word_t            dmag_r, dmag_nxt;
  logic             neg_q_r, neg_q_nxt;
  logic             neg_r_r, neg_r_nxt;

  word_t          shifted;
  logic [WIDTH:0] diff;
  word_t          nmag;
  word_t          dmag_in;

  assign nmag    = dividend[WIDTH-1] ? word_t'(-dividend) : word_t'(dividend);
  assign dmag_in = divisor[WIDTH-1]  ? word_t'(-divisor)  : word_t'(divisor);
  assign shifted = {rem_r[WIDTH-2:0], quo_r[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {1'b0, dmag_r};

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dmag_nxt  = dmag_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      run_nxt   = 1'b1;
      cnt_nxt   = CNT_W'(WIDTH - 1);
      quo_nxt   = nmag;
      rem_nxt   = '0;
      dmag_nxt  = dmag_in;
      neg_q_nxt = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      neg_r_nxt = dividend[WIDTH-1];
    end else if (run_r) begin
      quo_nxt = {quo_r[WIDTH-2:0], ~diff[WIDTH]};
      rem_nxt = diff[WIDTH] ? shifted : diff[WIDTH-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dmag_r  <= dmag_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quotient  = neg_q_r ? word_t'('0 - quo_r) : quo_r;
  assign remainder = neg_r_r ? $signed(word_t'('0 - rem_r)) : $signed(rem_r);

  `ASSERT_CLK_RST(a_done_single, clk, rst_n, stat.done |=> !stat.done, "divider done held")
  `ASSERT_CLK_RST(a_no_restart, clk, rst_n, start |-> !stat.busy, "divider restarted while busy")

endmodule

>>> rtl/extended_gcd_unit.sv
// ----------------------------------------------------------------------------
// extended_gcd_unit
// extended euclid: gcd with bezout coefficients, truncating signed division
// ----------------------------------------------------------------------------
// usage
//   input beat (in_a_value, in_b_value) is taken when in_valid is high and
//   in_stall is low; in_stall stays high from the beat until the result has
//   been written to the output register, so one item is in work at a time
//   result beat (out_divisor_value, out_coef_a, out_coef_b) with
//   in_a_value*out_coef_a + in_b_value*out_coef_b = out_divisor_value
//   each euclid step runs the bit-serial divider, then the two coefficient
//   updates share one multiplier; at most about 46 steps are needed at 32
//   bits, and a zero b_value goes from the check straight to the output
//   register
//   the output register holds a finished result while out_stall is high;
//   the next input beat is still taken, but its result waits until the
//   held beat has gone
//   synchronous active-low reset empties the output register and returns
//   the sequencer to idle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module extended_gcd_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [egcd_pkg::WIDTH-1:0] in_a_value,
  input  logic signed [egcd_pkg::WIDTH-1:0] in_b_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [egcd_pkg::WIDTH-1:0] out_divisor_value,
  output logic signed [egcd_pkg::WIDTH-1:0] out_coef_a,
  output logic signed [egcd_pkg::WIDTH-1:0] out_coef_b
);
  import egcd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MULS  = 3'd3;
  localparam logic [2:0] S_UPDS  = 3'd4;
  localparam logic [2:0] S_UPDT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [WIDTH-1:0] r0_r, r0_nxt, r1_r, r1_nxt, rem_r, rem_nxt;
  word_t              s0_r, s0_nxt, s1_r, s1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  word_t              q_r, q_nxt, prod_r, prod_nxt;
  logic signed [WIDTH-1:0] res_g_r, res_g_nxt;
  word_t              res_x_r, res_x_nxt, res_y_r, res_y_nxt;

  logic                    div_start;
  div_stat_t               div_stat;
  word_t                   div_quo;
  logic signed [WIDTH-1:0] div_rem;
  word_t                   mul_b;
  word_t                   mul_lo;
  logic                    in_take;
  logic                    out_free;

  egcd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (r0_r),
    .divisor   (r1_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // one multiplier, low half only, serves both coefficient rows
  assign mul_b  = (state_r == S_MULS) ? s1_r : t1_r;
  assign mul_lo = q_r * mul_b;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    rem_nxt       = rem_r;
    s0_nxt        = s0_r;
    s1_nxt        = s1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    res_g_nxt     = res_g_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    div_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          r0_nxt    = in_a_value;
          r1_nxt    = in_b_value;
          s0_nxt    = word_t'(1);
          s1_nxt    = '0;
          t0_nxt    = '0;
          t1_nxt    = word_t'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (r1_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          q_nxt     = div_quo;
          rem_nxt   = div_rem;
          state_nxt = S_MULS;
        end
      end
      S_MULS: begin
        prod_nxt  = mul_lo;
        state_nxt = S_UPDS;
      end
      S_UPDS: begin
        s0_nxt    = s1_r;
        s1_nxt    = s0_r - prod_r;
        prod_nxt  = mul_lo;
        state_nxt = S_UPDT;
      end
      S_UPDT: begin
        t0_nxt    = t1_r;
        t1_nxt    = t0_r - prod_r;
        r0_nxt    = r1_r;
        r1_nxt    = rem_r;
        state_nxt = S_CHECK;
      end
      S_OUT: begin
        if (out_free) begin
          res_g_nxt     = r0_r;
          res_x_nxt     = s0_r;
          res_y_nxt     = t0_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    rem_r   <= rem_nxt;
    s0_r    <= s0_nxt;
    s1_r    <= s1_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    q_r     <= q_nxt;
    prod_r  <= prod_nxt;
    res_g_r <= res_g_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_divisor_value = res_g_r;
  assign out_coef_a        = $signed(res_x_r);
  assign out_coef_b        = $signed(res_y_r);

  `ASSERT_CLK_RST(a_take_checks, clk, rst_n, in_take |=> state_r == S_CHECK, "beat not checked")
  `ASSERT_CLK_RST(a_done_in_div, clk, rst_n, div_stat.done |-> state_r == S_DIV, "stray div done")

endmodule
